// ----- sv/lgc_pkg.sv -----
// Package for the least-frequently-used glyph cache.
// Holds sizes and widths shared by lfu_glyph_cache, the checker and the testbench; no dependencies.
package lgc_pkg;

  localparam int CACHE_DEPTH = 64;
  localparam int COUNT_BITS  = 16;
  localparam int CODE_W      = 16;
  localparam int CAP_W       = 7;
  localparam int IDX_W       = $clog2(CACHE_DEPTH);
  localparam int FILL_W      = $clog2(CACHE_DEPTH + 1);
  localparam int CMP_W       = (CAP_W > FILL_W) ? CAP_W : FILL_W;
  localparam int ENTRY_W     = CODE_W + COUNT_BITS;
  localparam int CAP_RESET   = 64;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  typedef struct packed {
    logic [CODE_W-1:0]     code;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

endpackage

// ----- sv/lgc_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; used by lfu_glyph_cache for the entry store.
module lgc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/lfu_glyph_cache.sv -----
// Top level of the least-frequently-used glyph cache: sequencer, valid bits, scan logic.
// Depends on lgc_pkg and lgc_ram.
//
// Each transaction runs from start to the done strobe through a scan and a write: the
// entry store is one single-port-read RAM, and every lookup reads all entries through
// it, one per cycle, to find a match, the first free slot and the least-used victim,
// then writes the chosen entry back. busy is high from the cycle after start through
// the write state; a new start may be given in the done cycle. done_o is high for a
// single cycle; the result fields are registered and held until the next write. The
// store is cleared by reset through per-entry valid bits, so no clearing pass is needed.
// cfg_wdata_i sets the capacity limit (0 acts as 1, above the depth acts as the depth);
// write it only while busy is low.
module lfu_glyph_cache (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lgc_pkg::CAP_W-1:0]         cfg_wdata_i,
  input  logic                              start,
  output logic                              busy,
  input  logic [lgc_pkg::CODE_W-1:0]        char_code_i,
  output logic                              done_o,
  output logic                              hit_o,
  output logic [lgc_pkg::IDX_W-1:0]         slot_o,
  output logic                              evicted_o,
  output logic [lgc_pkg::CODE_W-1:0]        evicted_code_o,
  output logic [lgc_pkg::COUNT_BITS-1:0]    use_count_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [lgc_pkg::CAP_W-1:0]       cap_q;
  logic [lgc_pkg::FILL_W-1:0]      used_q;
  logic [lgc_pkg::CACHE_DEPTH-1:0] valid_q;
  logic [lgc_pkg::CODE_W-1:0]      key_q;
  logic [lgc_pkg::FILL_W-1:0]      cnt_q;
  logic                            proc_q;
  logic [lgc_pkg::IDX_W-1:0]       pidx_q;

  logic                            match_q;
  logic [lgc_pkg::IDX_W-1:0]       match_idx_q;
  logic [lgc_pkg::COUNT_BITS-1:0]  match_cnt_q;
  logic                            free_q;
  logic [lgc_pkg::IDX_W-1:0]       free_idx_q;
  logic                            vic_q;
  logic [lgc_pkg::IDX_W-1:0]       vic_idx_q;
  logic [lgc_pkg::COUNT_BITS-1:0]  vic_cnt_q;
  logic [lgc_pkg::CODE_W-1:0]      vic_code_q;

  logic                            done_q;
  logic                            hit_q;
  logic [lgc_pkg::IDX_W-1:0]       slot_q;
  logic                            evicted_q;
  logic [lgc_pkg::CODE_W-1:0]      evicted_code_q;
  logic [lgc_pkg::COUNT_BITS-1:0]  use_count_q;

  logic                            accept;
  logic                            scan_end;
  logic                            rd_en;
  lgc_pkg::entry_t                 rd_entry;
  lgc_pkg::entry_t                 wr_entry;
  logic                            wr_en;
  logic [lgc_pkg::IDX_W-1:0]       wr_idx;
  logic                            pv;
  logic                            better;
  logic [lgc_pkg::CMP_W-1:0]       cap_ext;
  logic [lgc_pkg::CMP_W-1:0]       eff_cap;
  logic [lgc_pkg::CMP_W-1:0]       used_ext;
  logic                            take_free;
  logic [lgc_pkg::COUNT_BITS-1:0]  hit_cnt;

  assign accept   = start && !busy;
  assign busy     = (state_q != ST_IDLE);
  assign scan_end = (cnt_q == lgc_pkg::FILL_W'(lgc_pkg::CACHE_DEPTH));
  assign rd_en    = (state_q == ST_SCAN) && !scan_end;
  assign pv       = valid_q[pidx_q];

  assign better = !vic_q || (rd_entry.count < vic_cnt_q) ||
                  ((rd_entry.count == vic_cnt_q) && (rd_entry.code < vic_code_q));

  assign cap_ext  = lgc_pkg::CMP_W'(cap_q);
  assign used_ext = lgc_pkg::CMP_W'(used_q);

  always_comb begin
    eff_cap = cap_ext;
    if (cap_ext == '0) begin
      eff_cap = lgc_pkg::CMP_W'(1);
    end else if (cap_ext > lgc_pkg::CMP_W'(lgc_pkg::CACHE_DEPTH)) begin
      eff_cap = lgc_pkg::CMP_W'(lgc_pkg::CACHE_DEPTH);
    end
  end

  assign take_free = free_q && (used_ext < eff_cap);
  assign hit_cnt   = (match_cnt_q == lgc_pkg::COUNT_MAX) ? lgc_pkg::COUNT_MAX
                                                         : match_cnt_q + lgc_pkg::COUNT_ONE;

  always_comb begin
    wr_en          = (state_q == ST_WRITE);
    wr_entry.code  = key_q;
    wr_entry.count = lgc_pkg::COUNT_ONE;
    wr_idx         = vic_idx_q;
    if (match_q) begin
      wr_entry.count = hit_cnt;
      wr_idx         = match_idx_q;
    end else if (take_free) begin
      wr_idx = free_idx_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end && !proc_q) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  lgc_ram #(
    .WIDTH (lgc_pkg::ENTRY_W),
    .DEPTH (lgc_pkg::CACHE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_idx),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (cnt_q[lgc_pkg::IDX_W-1:0]),
    .rdata_o (rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cap_q   <= lgc_pkg::CAP_W'(lgc_pkg::CAP_RESET);
      used_q  <= '0;
      valid_q <= '0;
      cnt_q   <= '0;
      proc_q  <= 1'b0;
      match_q <= 1'b0;
      free_q  <= 1'b0;
      vic_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_WRITE);
      proc_q  <= rd_en;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept) begin
        cnt_q   <= '0;
        match_q <= 1'b0;
        free_q  <= 1'b0;
        vic_q   <= 1'b0;
      end else if (rd_en) begin
        cnt_q <= cnt_q + lgc_pkg::FILL_W'(1);
      end
      if (proc_q) begin
        if (pv && (rd_entry.code == key_q) && !match_q) begin
          match_q <= 1'b1;
        end
        if (!pv && !free_q) begin
          free_q <= 1'b1;
        end
        if (pv && better) begin
          vic_q <= 1'b1;
        end
      end
      if (wr_en) begin
        valid_q[wr_idx] <= 1'b1;
        if (!match_q && take_free) begin
          used_q <= used_q + lgc_pkg::FILL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= cnt_q[lgc_pkg::IDX_W-1:0];
    if (accept) begin
      key_q <= char_code_i;
    end
    if (proc_q) begin
      if (pv && (rd_entry.code == key_q) && !match_q) begin
        match_idx_q <= pidx_q;
        match_cnt_q <= rd_entry.count;
      end
      if (!pv && !free_q) begin
        free_idx_q <= pidx_q;
      end
      if (pv && better) begin
        vic_idx_q  <= pidx_q;
        vic_cnt_q  <= rd_entry.count;
        vic_code_q <= rd_entry.code;
      end
    end
    if (wr_en) begin
      hit_q          <= match_q;
      slot_q         <= wr_idx;
      evicted_q      <= !match_q && !take_free;
      evicted_code_q <= (!match_q && !take_free) ? vic_code_q : '0;
      use_count_q    <= wr_entry.count;
    end
  end

  assign done_o         = done_q;
  assign hit_o          = hit_q;
  assign slot_o         = slot_q;
  assign evicted_o      = evicted_q;
  assign evicted_code_o = evicted_code_q;
  assign use_count_o    = use_count_q;

endmodule

// ----- dv/lfu_lookup_checker.sv -----
// Checker for the least-frequently-used glyph cache: watches the lookup and result channels,
// predicts every result from its own model of the cache and compares it field by field.
// Depends on lgc_pkg.
module lfu_lookup_checker
  import lgc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CAP_W-1:0]      cfg_wdata_i,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic [CODE_W-1:0]     char_code_i,
  input  logic                  done_i,
  input  logic                  hit_i,
  input  logic [IDX_W-1:0]      slot_i,
  input  logic                  evicted_i,
  input  logic [CODE_W-1:0]     evicted_code_i,
  input  logic [COUNT_BITS-1:0] use_count_i,
  output int                    pending_o,
  output int                    mismatches_o
);

  typedef struct packed {
    logic                  hit;
    logic [IDX_W-1:0]      slot;
    logic                  evicted;
    logic [CODE_W-1:0]     evicted_code;
    logic [COUNT_BITS-1:0] use_count;
  } lookup_result_t;

  logic                  ent_valid [CACHE_DEPTH];
  logic [CODE_W-1:0]     ent_code  [CACHE_DEPTH];
  logic [COUNT_BITS-1:0] ent_count [CACHE_DEPTH];
  int                    fill;
  logic [CAP_W-1:0]      capacity;
  lookup_result_t        expected_lookups [$];
  lookup_result_t        oldest;

  function automatic lookup_result_t predict_lookup(input logic [CODE_W-1:0] code);
    lookup_result_t r;
    int idx;
    int limit;
    r = '0;
    idx = -1;
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      if (ent_valid[i] && ent_code[i] == code) begin
        idx = i;
        break;
      end
    end
    if (idx >= 0) begin
      r.hit = 1'b1;
      if (ent_count[idx] != COUNT_MAX) ent_count[idx] = ent_count[idx] + 1'b1;
    end else begin
      limit = (capacity == 0) ? 1 : ((capacity > CACHE_DEPTH) ? CACHE_DEPTH : int'(capacity));
      if (fill < limit) begin
        for (int i = 0; i < CACHE_DEPTH; i++) begin
          if (!ent_valid[i]) begin
            idx = i;
            break;
          end
        end
      end
      if (idx >= 0) begin
        fill++;
      end else begin
        for (int i = 0; i < CACHE_DEPTH; i++) begin
          if (ent_valid[i] && (idx < 0 || ent_count[i] < ent_count[idx] ||
              (ent_count[i] == ent_count[idx] && ent_code[i] < ent_code[idx]))) begin
            idx = i;
          end
        end
        r.evicted      = 1'b1;
        r.evicted_code = ent_code[idx];
      end
      ent_valid[idx] = 1'b1;
      ent_code[idx]  = code;
      ent_count[idx] = COUNT_ONE;
    end
    r.slot      = IDX_W'(idx);
    r.use_count = ent_count[idx];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        ent_valid[i] = 1'b0;
        ent_code[i]  = '0;
        ent_count[i] = '0;
      end
      fill         = 0;
      capacity     = CAP_W'(CAP_RESET);
      expected_lookups.delete();
      pending_o    = 0;
      mismatches_o = 0;
    end else begin
      if (done_i) begin
        if (expected_lookups.size() == 0) begin
          $display("%0t: result with no transaction outstanding, actual slot %0h code %0h",
                   $time, slot_i, evicted_code_i);
          mismatches_o++;
        end else begin
          oldest = expected_lookups.pop_front();
          check_field("hit", oldest.hit, hit_i);
          check_field("slot", oldest.slot, slot_i);
          check_field("evicted", oldest.evicted, evicted_i);
          check_field("evicted_code", oldest.evicted_code, evicted_code_i);
          check_field("use_count", oldest.use_count, use_count_i);
        end
      end
      if (cfg_we_i) capacity = cfg_wdata_i;
      if (start_i && !busy_i) expected_lookups.push_back(predict_lookup(char_code_i));
      pending_o = expected_lookups.size();
    end
  end

endmodule

// ----- dv/testbench.sv -----
// Top of the glyph cache testbench: clock, reset, lookup stimulus and capacity writes.
// Instantiates lfu_glyph_cache beside lfu_lookup_checker, which predicts and compares.
// Depends on lgc_pkg, lfu_glyph_cache and lfu_lookup_checker.
module testbench;
  import lgc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CAP_W-1:0]      cfg_wdata = '0;
  logic                  start     = 1'b0;
  logic [CODE_W-1:0]     char_code = '0;
  logic                  busy;
  logic                  done;
  logic                  hit;
  logic [IDX_W-1:0]      slot;
  logic                  evicted;
  logic [CODE_W-1:0]     evicted_code;
  logic [COUNT_BITS-1:0] use_count;
  int                    pending;
  int                    mismatches;
  int                    quiet_cycles = 0;
  int                    idle_pct     = 38;

  lfu_glyph_cache dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .start          (start),
    .busy           (busy),
    .char_code_i    (char_code),
    .done_o         (done),
    .hit_o          (hit),
    .slot_o         (slot),
    .evicted_o      (evicted),
    .evicted_code_o (evicted_code),
    .use_count_o    (use_count)
  );

  lfu_lookup_checker lookup_chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .start_i        (start),
    .busy_i         (busy),
    .char_code_i    (char_code),
    .done_i         (done),
    .hit_i          (hit),
    .slot_i         (slot),
    .evicted_i      (evicted),
    .evicted_code_i (evicted_code),
    .use_count_i    (use_count),
    .pending_o      (pending),
    .mismatches_o   (mismatches)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_code(input logic [CODE_W-1:0] code);
    int gap;
    gap = ($urandom_range(99, 0) < idle_pct) ? $urandom_range(90, 1) : 0;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start     <= 1'b1;
    char_code <= code;
    do @(posedge clk); while (!(start && !busy));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int n_items, input int pct,
                           input int pool_n);
    logic [CODE_W-1:0] pool [$];
    logic [CODE_W-1:0] code;
    write_capacity(cap);
    idle_pct = pct;
    repeat (pool_n) pool.push_back(CODE_W'($urandom));
    for (int k = 0; k < n_items; k++) begin
      if (k == n_items / 2) wait_drained();
      if ($urandom_range(99, 0) < 70) code = pool[$urandom_range(pool_n - 1, 0)];
      else code = CODE_W'($urandom);
      send_code(code);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // capacity of zero behaves as one
    write_capacity('0);
    send_code(16'hFFFF);
    send_code(16'h0000);
    send_code(16'h0000);
    send_code(16'hFFFF);
    // tie on count goes to the smaller code, here in the higher slot
    write_capacity(CAP_W'(2));
    send_code(16'h8000);
    send_code(16'h7FFF);
    send_code(16'h7FFF);
    send_code(16'h7FFF);
    send_code(16'h1111);
    // capacity lowered below occupancy: evict, never take a free entry
    write_capacity(CAP_W'(1));
    send_code(16'h5555);
    send_code(16'hAAAA);
    // capacity above the depth behaves as the depth
    write_capacity('1);
    send_code(16'h0001);
    send_code(16'hFFFE);
    send_code(16'h0000);
    send_code(16'hAAAA);
    send_code(16'h7FFF);

    run_phase(CAP_W'(3), 150, 38, 5);
    run_phase(CAP_W'(1), 100, 38, 3);
    run_phase(CAP_W'(8), 150, 38, 12);
    run_phase('0, 80, 38, 2);
    run_phase(CAP_W'(20), 200, 38, 30);
    run_phase('1, 300, 0, 90);
    run_phase(CAP_W'(64), 250, 38, 80);
    run_phase(CAP_W'($urandom_range(63, 1)), 220, 38, 40);

    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
